/* sv/distance_vector_route_table_core_defines.svh */
// Assertion macros for the distance-vector route table core.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_CORE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_CORE_DEFINES_SVH

// check a property outside reset
`define DVRT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("dvrt assertion failed");

// check a property on every edge, reset included
`define DVRT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("dvrt assertion failed");

`endif

/* sv/dvrt_pkg.sv */
// Shared types and constants of the distance-vector route table core.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package dvrt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int MAX_RESULTS = 32;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   localparam logic [4:0] METRIC_INF = 5'd16;
   localparam logic [7:0] DEFAULT_TIMEOUT = 8'd180;

   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_STATIC = 2'd1;
   localparam logic [1:0] ACT_RESP = 2'd2;
   localparam logic [1:0] ACT_DUMP = 2'd3;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT_ADDR = 3'd0;

   typedef struct packed {
      logic [31:0] prefix;
      logic [31:0] mask;
      logic [31:0] hop;
      logic [4:0]  metric;
      logic [7:0]  age;
   } row_type;

   typedef struct packed {
      logic load;
      logic idx_clr;
      logic idx_inc;
      logic rd;
      logic age_upd;
      logic ins;
      logic evict;
      logic chg_clr;
      logic trig_set;
      logic trig_val;
      logic take;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       pfx_zero;
      logic       last;
      logic       changed;
      logic       idx_end;
      logic       used_here;
      logic       match;
      logic       replace;
      logic       dump_hit;
      logic       pend_valid;
      logic       cnt_full;
      logic       out_free;
   } status_type;

endpackage
`default_nettype wire

/* sv/dvrt_ctrl.sv */
// Sequencer of the route table: walks the table for tick, insert, match and dump.
// Depends on dvrt_pkg; drives dvrt_dp through cmd_type and reads status_type.
`default_nettype none
module dvrt_ctrl
   import dvrt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type st,
   output cmd_type         cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DSP  = 4'd1;
   localparam logic [3:0] S_TRD  = 4'd2;
   localparam logic [3:0] S_TEV  = 4'd3;
   localparam logic [3:0] S_FSC  = 4'd4;
   localparam logic [3:0] S_MRD  = 4'd5;
   localparam logic [3:0] S_MEV  = 4'd6;
   localparam logic [3:0] S_PEND = 4'd7;
   localparam logic [3:0] S_DRD  = 4'd8;
   localparam logic [3:0] S_DEV  = 4'd9;
   localparam logic [3:0] S_DFL  = 4'd10;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DSP;
            end
         end
         S_DSP: begin
            cmd.idx_clr = 1'b1;
            unique case (st.action)
               ACT_TICK: state_in = S_TRD;
               ACT_STATIC: state_in = st.pfx_zero ? S_IDLE : S_FSC;
               ACT_RESP: state_in = S_MRD;
               default: begin
                  cmd.trig_set = 1'b1;
                  cmd.trig_val = 1'b0;
                  state_in = S_DRD;
               end
            endcase
         end
         S_TRD: begin
            cmd.rd = 1'b1;
            state_in = S_TEV;
         end
         S_TEV: begin
            cmd.age_upd = 1'b1;
            if (st.idx_end) begin
               state_in = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in = S_TRD;
            end
         end
         S_FSC: begin
            if (!st.used_here) begin
               cmd.ins = 1'b1;
               state_in = (st.action == ACT_RESP) ? S_PEND : S_IDLE;
            end else if (st.idx_end) begin
               state_in = (st.action == ACT_RESP) ? S_PEND : S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_MRD: begin
            cmd.rd = 1'b1;
            state_in = S_MEV;
         end
         S_MEV: begin
            if (st.match) begin
               if (st.replace) begin
                  cmd.evict = 1'b1;
                  cmd.idx_clr = 1'b1;
                  state_in = S_FSC;
               end else begin
                  state_in = S_PEND;
               end
            end else if (st.idx_end) begin
               cmd.idx_clr = 1'b1;
               state_in = S_FSC;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in = S_MRD;
            end
         end
         S_PEND: begin
            state_in = S_IDLE;
            if (st.last) begin
               cmd.chg_clr = 1'b1;
               if (st.changed) begin
                  cmd.trig_set = 1'b1;
                  cmd.trig_val = 1'b1;
                  cmd.idx_clr = 1'b1;
                  state_in = S_DRD;
               end
            end
         end
         S_DRD: begin
            cmd.rd = 1'b1;
            state_in = S_DEV;
         end
         S_DEV: begin
            if (st.dump_hit) begin
               if (!st.pend_valid || st.out_free) begin
                  cmd.take = 1'b1;
                  if (st.cnt_full || st.idx_end) begin
                     state_in = S_DFL;
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in = S_DRD;
                  end
               end
            end else if (st.idx_end) begin
               state_in = S_DFL;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in = S_DRD;
            end
         end
         S_DFL: begin
            if (st.out_free) begin
               cmd.flush = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* sv/dvrt_dp.sv */
// Datapath of the route table: route memory, valid and static bits, item
// registers, dump buffer and result register. Depends on dvrt_pkg and the defines.
`default_nettype none
`include "distance_vector_route_table_core_defines.svh"
module dvrt_dp
   import dvrt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   output status_type        st,
   input  wire logic [7:0]   timeout,
   input  wire logic [1:0]   req_action,
   input  wire logic [31:0]  req_prefix,
   input  wire logic [31:0]  req_mask,
   input  wire logic [31:0]  req_source,
   input  wire logic [4:0]   req_metric,
   input  wire logic         req_last,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_prefix,
   output logic [31:0]       rsp_mask,
   output logic [4:0]        rsp_metric,
   output logic              rsp_valid_flag,
   output logic              rsp_trig_flag,
   output logic              rsp_last
);

   row_type mem [TABLE_DEPTH];
   row_type rd_ff;
   logic [TABLE_DEPTH-1:0] used_ff, used_in, static_ff, static_in;
   logic [IDX_W-1:0] idx_ff;
   logic [1:0]  act_ff;
   logic [31:0] pfx_ff, msk_ff, src_ff;
   logic [4:0]  met_ff;
   logic        last_ff;
   logic        chg_ff, trig_ff;
   row_type     pend_ff;
   logic        pend_v_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic        out_v_ff;
   logic [31:0] out_pfx_ff, out_msk_ff;
   logic [4:0]  out_met_ff;
   logic        out_valid_ff, out_trig_ff, out_last_ff;
   logic [4:0]  met_clamp, new_met;
   logic        ins_static, age_live, age_expire, out_free;
   row_type     ins_row, age_row;

   assign met_clamp = (req_metric > METRIC_INF) ? METRIC_INF : req_metric;
   assign new_met = (met_ff == METRIC_INF) ? METRIC_INF : met_ff + 5'd1;
   assign ins_static = (act_ff == ACT_STATIC);
   assign age_live = used_ff[idx_ff] && !static_ff[idx_ff];
   assign age_expire = (rd_ff.age <= 8'd1);
   assign out_free = !out_v_ff || rsp_tready;

   always_comb begin
      ins_row.prefix = pfx_ff;
      ins_row.mask = msk_ff;
      ins_row.hop = src_ff;
      ins_row.metric = ins_static ? 5'd0 : new_met;
      ins_row.age = timeout;
      age_row = rd_ff;
      age_row.age = rd_ff.age - 8'd1;
   end

   always_comb begin
      st.action = act_ff;
      st.pfx_zero = (pfx_ff == 32'd0);
      st.last = last_ff;
      st.changed = chg_ff;
      st.idx_end = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
      st.used_here = used_ff[idx_ff];
      st.match = used_ff[idx_ff] && rd_ff.prefix == pfx_ff && rd_ff.mask == msk_ff;
      st.replace = (rd_ff.hop == src_ff) || ({1'b0, met_ff} + 6'd1 < {1'b0, rd_ff.metric});
      st.dump_hit = used_ff[idx_ff] && rd_ff.metric != METRIC_INF;
      st.pend_valid = pend_v_ff;
      st.cnt_full = (cnt_ff == CNT_W'(MAX_RESULTS - 1));
      st.out_free = out_free;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_ff <= mem[idx_ff];
      end
      if (cmd.ins && !used_ff[idx_ff]) begin
         mem[idx_ff] <= ins_row;
      end else if (cmd.age_upd && age_live && !age_expire) begin
         mem[idx_ff] <= age_row;
      end
   end

   always_comb begin
      used_in = used_ff;
      static_in = static_ff;
      if (cmd.ins && !used_ff[idx_ff]) begin
         used_in[idx_ff] = 1'b1;
         static_in[idx_ff] = ins_static;
      end
      if (cmd.evict) begin
         used_in[idx_ff] = 1'b0;
         static_in[idx_ff] = 1'b0;
      end
      if (cmd.age_upd && age_live && age_expire) begin
         used_in[idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         pfx_ff <= req_prefix;
         msk_ff <= req_mask;
         src_ff <= req_source;
         met_ff <= met_clamp;
         last_ff <= req_last;
      end
      if (cmd.take) begin
         pend_ff <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         static_ff <= '0;
         idx_ff <= '0;
         chg_ff <= 1'b0;
         trig_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         cnt_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         static_ff <= static_in;
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.chg_clr) begin
            chg_ff <= 1'b0;
         end else if (cmd.ins && !used_ff[idx_ff] && act_ff == ACT_RESP) begin
            chg_ff <= 1'b1;
         end
         if (cmd.trig_set) begin
            trig_ff <= cmd.trig_val;
         end
         if (cmd.take) begin
            pend_v_ff <= 1'b1;
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (cmd.flush) begin
            pend_v_ff <= 1'b0;
            cnt_ff <= '0;
         end
         if ((cmd.take && pend_v_ff) || cmd.flush) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && pend_v_ff) begin
         out_pfx_ff <= pend_ff.prefix;
         out_msk_ff <= pend_ff.mask;
         out_met_ff <= pend_ff.metric;
         out_valid_ff <= 1'b1;
         out_last_ff <= 1'b0;
         out_trig_ff <= trig_ff;
      end else if (cmd.flush) begin
         out_pfx_ff <= pend_v_ff ? pend_ff.prefix : 32'd0;
         out_msk_ff <= pend_v_ff ? pend_ff.mask : 32'd0;
         out_met_ff <= pend_v_ff ? pend_ff.metric : 5'd0;
         out_valid_ff <= pend_v_ff;
         out_last_ff <= 1'b1;
         out_trig_ff <= trig_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_prefix = out_pfx_ff;
   assign rsp_mask = out_msk_ff;
   assign rsp_metric = out_met_ff;
   assign rsp_valid_flag = out_valid_ff;
   assign rsp_trig_flag = out_trig_ff;
   assign rsp_last = out_last_ff;

   `DVRT_ASSERT_ALWAYS(a_reset_clears_table, reset |=> (used_ff == '0 && static_ff == '0))
   `DVRT_ASSERT(a_load_only_when_free, (cmd.flush || (cmd.take && pend_v_ff)) |-> out_free)
   `DVRT_ASSERT(a_count_bounded, cnt_ff <= CNT_W'(MAX_RESULTS))
   `DVRT_ASSERT(a_static_implies_used, (static_ff & ~used_ff) == '0)

endmodule
`default_nettype wire

/* sv/distance_vector_route_table_core.sv */
// Distance-vector route table core: stream ports, register port, controller and datapath.
// Depends on dvrt_pkg, dvrt_ctrl and dvrt_dp.
//
// Usage: route items enter on the req_ stream (tuser = action, tlast = end of
// response packet). Table dumps leave on the rsp_ stream, one beat per route,
// tlast on the final beat; an empty dump gives one marker beat with out_valid 0.
// The csr_ port holds the route timeout in ticks (byte address 0, reset 180).
// Every item walks the table of TABLE_DEPTH slots through the single route
// memory. A tick visits every slot; a static add scans the valid bits for a
// free slot; a response searches for a match, then a free slot if it inserts;
// a dump ends after MAX_RESULTS routes or at the table end, pausing on stalls.
// A memory read takes a read state and an evaluate state, as it is registered.
// Reset empties the table at once (valid bits) and restores the timeout.
// When the receiver stalls, the result register holds its beat and the dump
// walk pauses with the next route kept in a one-beat buffer; req_tready is
// low until the current item is finished.
`default_nettype none
module distance_vector_route_table_core
   import dvrt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [31:0] route_prefix, [63:32] route_mask, [95:64] source_addr,
   // [100:96] received_metric, [103:101] zero
   input  wire logic [103:0]          req_tdata,
   // [1:0] action
   input  wire logic [1:0]            req_tuser,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [31:0] out_prefix, [63:32] out_mask, [68:64] out_metric, [71:69] zero
   output logic [71:0]                rsp_tdata,
   // [0] out_valid, [1] is_triggered
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [7:0] timeout_ff;
   cmd_type    cmd;
   status_type st;
   logic [31:0] out_pfx, out_msk;
   logic [4:0]  out_met;
   logic        out_vflag, out_tflag;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= DEFAULT_TIMEOUT;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == CSR_TIMEOUT_ADDR) begin
         timeout_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_TIMEOUT_ADDR: csr_prdata = {24'd0, timeout_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   dvrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   dvrt_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .timeout        (timeout_ff),
      .req_action     (req_tuser),
      .req_prefix     (req_tdata[31:0]),
      .req_mask       (req_tdata[63:32]),
      .req_source     (req_tdata[95:64]),
      .req_metric     (req_tdata[100:96]),
      .req_last       (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_prefix     (out_pfx),
      .rsp_mask       (out_msk),
      .rsp_metric     (out_met),
      .rsp_valid_flag (out_vflag),
      .rsp_trig_flag  (out_tflag),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {3'd0, out_met, out_msk, out_pfx};
   assign rsp_tuser = {out_tflag, out_vflag};

endmodule
`default_nettype wire

/* bench/distance_vector_route_table_core_test.sv */
// Self-checking bench for the distance-vector route table core: directed rows, then
// random response packets, ticks, static adds and dumps checked against a route-table predictor.
// Depends on dvrt_pkg and the distance_vector_route_table_core RTL.
`default_nettype none
module distance_vector_route_table_core_test;
   import dvrt_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [1:0]  action;
      logic [31:0] prefix;
      logic [31:0] mask;
      logic [31:0] src;
      logic [4:0]  metric;
      logic        last;
   } route_item_t;

   typedef struct packed {
      logic [31:0] prefix;
      logic [31:0] mask;
      logic [4:0]  metric;
      logic        valid;
      logic        last;
      logic        trig;
   } advert_t;

   typedef struct {
      route_item_t item;
      bit          has_exp;
      advert_t     exp_beat;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [103:0] req_tdata = '0;
   logic [1:0] req_tuser = ACT_TICK;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = CSR_TIMEOUT_ADDR;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   distance_vector_route_table_core dut (.*);

   always #5 clock = ~clock;

   // predictor state
   bit          rt_used[TABLE_DEPTH];
   bit          rt_static[TABLE_DEPTH];
   logic [31:0] rt_prefix[TABLE_DEPTH];
   logic [31:0] rt_mask[TABLE_DEPTH];
   logic [31:0] rt_hop[TABLE_DEPTH];
   logic [4:0]  rt_metric[TABLE_DEPTH];
   logic [7:0]  rt_age[TABLE_DEPTH];
   bit          pkt_changed;
   logic [7:0]  timeout_ticks;

   advert_t pending_adverts[$];
   int mismatches = 0;
   int idle_cycles = 0;
   logic [31:0] known_prefix[$];
   logic [31:0] known_hop[$];

   function automatic bit place_route(logic [31:0] p, logic [31:0] m, logic [31:0] h,
                                      logic [4:0] met, bit st);
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (!rt_used[i]) begin
            rt_used[i] = 1; rt_static[i] = st; rt_prefix[i] = p; rt_mask[i] = m;
            rt_hop[i] = h; rt_metric[i] = met; rt_age[i] = timeout_ticks;
            return 1;
         end
      return 0;
   endfunction

   function automatic void queue_table_dump(bit trig);
      advert_t a;
      int n;
      n = 0;
      for (int i = 0; i < TABLE_DEPTH && n < MAX_RESULTS; i++)
         if (rt_used[i] && rt_metric[i] != METRIC_INF) begin
            a.prefix = rt_prefix[i]; a.mask = rt_mask[i]; a.metric = rt_metric[i];
            a.valid = 1; a.last = 0; a.trig = trig;
            pending_adverts.push_back(a);
            n++;
         end
      if (n == 0) begin
         a.prefix = 0; a.mask = 0; a.metric = 0; a.valid = 0; a.last = 1; a.trig = trig;
         pending_adverts.push_back(a);
      end else
         pending_adverts[$].last = 1;
   endfunction

   function automatic bit apply_response(route_item_t it, logic [5:0] m);
      logic [4:0] newm;
      int hit;
      newm = (m + 1 > 16) ? METRIC_INF : 5'(m + 1);
      hit = -1;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (rt_used[i] && rt_prefix[i] == it.prefix && rt_mask[i] == it.mask) begin
            hit = i;
            break;
         end
      if (hit < 0) return place_route(it.prefix, it.mask, it.src, newm, 0);
      if (rt_hop[hit] == it.src || (m + 1) < rt_metric[hit]) begin
         rt_used[hit] = 0; rt_static[hit] = 0;
         void'(place_route(it.prefix, it.mask, it.src, newm, 0));
         return 1;
      end
      return 0;
   endfunction

   function automatic void predict_route_item(route_item_t it);
      logic [5:0] m;
      bit ch;
      m = (it.metric > 16) ? 6'd16 : {1'b0, it.metric};
      case (it.action)
         ACT_TICK: begin
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (rt_used[i] && !rt_static[i]) begin
                  if (rt_age[i] <= 1) rt_used[i] = 0;
                  else rt_age[i]--;
               end
         end
         ACT_STATIC: begin
            if (it.prefix != 0) void'(place_route(it.prefix, it.mask, it.src, 5'd0, 1));
         end
         ACT_RESP: begin
            if (apply_response(it, m)) pkt_changed = 1;
            if (it.last) begin
               ch = pkt_changed;
               pkt_changed = 0;
               if (ch) queue_table_dump(1);
            end
         end
         default: queue_table_dump(0);
      endcase
   endfunction

   // result checking
   always @(posedge clock) begin
      advert_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_adverts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %h user %b", rsp_tdata, rsp_tuser);
         end else begin
            e = pending_adverts.pop_front();
            if (rsp_tdata[31:0] !== e.prefix || rsp_tdata[63:32] !== e.mask ||
                  rsp_tdata[68:64] !== e.metric || rsp_tuser[0] !== e.valid ||
                  rsp_tuser[1] !== e.trig || rsp_tlast !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %h %h %0d v%b t%b l%b got %h %h %0d v%b t%b l%b",
                     e.prefix, e.mask, e.metric, e.valid, e.trig, e.last,
                     rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[68:64],
                     rsp_tuser[0], rsp_tuser[1], rsp_tlast);
            end
         end
      end
   end

   // receiver stall pattern
   int stall_mode = 0;
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("distance_vector_route_table_core_test NOT OK");
         $finish;
      end
   end

   int gap_left = 0;
   int burst_left = 0;

   task automatic send_route_item(route_item_t it);
      if (burst_left == 0) begin
         gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 8);
      end
      if (gap_left > 0) req_tvalid <= 1'b0;
      while (gap_left > 0) begin
         @(posedge clock);
         gap_left--;
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, it.metric, it.src, it.mask, it.prefix};
      req_tuser <= it.action;
      req_tlast <= it.last;
      do @(posedge clock); while (!req_tready);
      predict_route_item(it);
   endtask

   task automatic write_timeout(logic [7:0] v);
      @(posedge clock);
      req_tvalid <= 1'b0;
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= CSR_TIMEOUT_ADDR; csr_pwdata <= {24'd0, v};
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      timeout_ticks = v;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_adverts.size() != 0) @(posedge clock);
      repeat (4 * TABLE_DEPTH + 20) @(posedge clock);
   endtask

   function automatic route_item_t make_item(logic [1:0] a, logic [31:0] p, logic [31:0] m,
                                            logic [31:0] s, logic [4:0] met, logic l);
      route_item_t it;
      it.action = a; it.prefix = p; it.mask = m; it.src = s; it.metric = met; it.last = l;
      return it;
   endfunction

   function automatic route_item_t random_item();
      route_item_t it;
      int r;
      it.prefix = (known_prefix.size() > 0 && $urandom_range(0, 2) != 0) ?
         known_prefix[$urandom_range(0, known_prefix.size() - 1)] : $urandom();
      it.mask = ($urandom_range(0, 3) != 0) ? 32'hFFFFFF00 : $urandom();
      it.src = ($urandom_range(0, 1) == 1) ? known_hop[$urandom_range(0, 2)] : $urandom();
      it.metric = ($urandom_range(0, 7) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 16));
      it.last = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) it.action = ACT_RESP;
      else if (r < 78) it.action = ACT_TICK;
      else if (r < 90) it.action = ACT_STATIC;
      else it.action = ACT_DUMP;
      if (it.action == ACT_STATIC && $urandom_range(0, 9) == 0) it.prefix = 0;
      return it;
   endfunction

   stim_row_t directed_rows[$];
   advert_t marker;

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         rt_used[i] = 0; rt_static[i] = 0;
      end
      pkt_changed = 0;
      timeout_ticks = DEFAULT_TIMEOUT;
      known_hop = '{32'h0A000001, 32'h0A000002, 32'hFFFFFFFF};
      for (int i = 0; i < 12; i++) known_prefix.push_back({8'hC0, 8'hA8, 8'(i), 8'h00});

      marker = '{prefix: 0, mask: 0, metric: 0, valid: 0, last: 1, trig: 0};
      directed_rows.push_back('{make_item(ACT_DUMP, 0, 0, 0, 0, 0), 1, marker});
      directed_rows.push_back('{make_item(ACT_STATIC, 0, 32'hFFFFFFFF, 1, 0, 0), 0, marker});
      directed_rows.push_back('{make_item(ACT_DUMP, 32'hFFFFFFFF, 0, 0, 31, 1), 1, marker});
      directed_rows.push_back('{make_item(ACT_STATIC, 32'hFFFFFFFF, 32'hFFFFFFFF,
         32'hFFFFFFFF, 31, 1), 0, marker});
      directed_rows.push_back('{make_item(ACT_RESP, 32'h0A000000, 32'hFF000000,
         32'h01010101, 0, 0), 0, marker});
      directed_rows.push_back('{make_item(ACT_RESP, 32'h0B000000, 32'hFF000000,
         32'h01010101, 16, 0), 0, marker});
      directed_rows.push_back('{make_item(ACT_RESP, 32'h0C000000, 32'hFFFF0000,
         32'h02020202, 31, 1), 0, marker});
      directed_rows.push_back('{make_item(ACT_RESP, 32'h0A000000, 32'hFF000000,
         32'h03030303, 5, 0), 0, marker});
      directed_rows.push_back('{make_item(ACT_RESP, 32'h0B000000, 32'hFF000000,
         32'h03030303, 3, 0), 0, marker});
      directed_rows.push_back('{make_item(ACT_RESP, 32'hFFFFFFFF, 32'hFFFFFFFF,
         32'h04040404, 2, 1), 0, marker});
      directed_rows.push_back('{make_item(ACT_RESP, 32'h0A000000, 32'hFF000000,
         32'h01010101, 15, 1), 0, marker});
      directed_rows.push_back('{make_item(ACT_RESP, 32'h0D000000, 32'hFF000000,
         32'h01010101, 4, 1), 0, marker});
      directed_rows.push_back('{make_item(ACT_TICK, 0, 0, 0, 0, 0), 0, marker});
      directed_rows.push_back('{make_item(ACT_DUMP, 0, 0, 0, 0, 0), 0, marker});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         send_route_item(directed_rows[r].item);
         if (directed_rows[r].has_exp && (pending_adverts.size() == 0 ||
               pending_adverts[$] != directed_rows[r].exp_beat)) begin
            mismatches++;
            $display("directed row %0d: predicted beat disagrees with table", r);
         end
      end
      wait_drained();

      // fill the table past its depth, then set a short timeout and send a tick and a dump
      write_timeout(8'd255);
      for (int i = 0; i < TABLE_DEPTH + 3; i++)
         send_route_item(make_item(ACT_RESP, 32'h20000000 + (i << 8), 32'hFFFFFF00,
            32'h0A000001, 5'(i % 17), (i % 8 == 7)));
      send_route_item(make_item(ACT_STATIC, 32'h30000000, 32'hFFFFFF00, 32'h1, 0, 0));
      send_route_item(make_item(ACT_DUMP, 0, 0, 0, 0, 0));
      wait_drained();
      write_timeout(8'd1);
      send_route_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
      send_route_item(make_item(ACT_DUMP, 0, 0, 0, 0, 0));
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_timeout(8'd3);
            1: write_timeout(8'd0);
            2: write_timeout(8'($urandom_range(2, 20)));
            default: write_timeout(DEFAULT_TIMEOUT);
         endcase
         for (int n = 0; n < 70; n++) send_route_item(random_item());
         send_route_item(make_item(ACT_RESP, $urandom(), $urandom(), $urandom(),
            5'($urandom_range(0, 14)), 1));
         wait_drained();
      end

      if (mismatches == 0)
         $display("distance_vector_route_table_core_test OK");
      else
         $display("distance_vector_route_table_core_test NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
